>>> rtl/dtko_pkg.sv
// -----------------------------------------------------------------------------
// Double-tap key override package
// Shared widths, codes, item types and helpers for the override unit.
// -----------------------------------------------------------------------------
`default_nettype none

package dtko_pkg;

  // Table size and the widths that follow from it.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Fixed field widths of the item formats.
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = 4;
  localparam int KIND_W  = 2;
  localparam int TERM_W  = 16;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_KEY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_PASS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SINGLE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TERM    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [TERM_W-1:0]  TAP_TERM_RST    = 16'd200;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 5'd0;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic               is_press;
    logic [CODE_W-1:0]  key_code;
    logic [BYTE_W-1:0]  matrix_row;
    logic [BYTE_W-1:0]  matrix_col;
    logic [BYTE_W-1:0]  mods_held;
    logic [CODE_W-1:0]  now_ms;
    logic [ENTRY_W-1:0] entry_index;
    logic               entry_by_position;
    logic [CODE_W-1:0]  entry_base_id;
    logic [CODE_W-1:0]  entry_single_code;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  out_code;
    logic [ENTRY_W-1:0] out_entry;
    logic               last;
  } result_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic               we;
    logic [ENTRY_W-1:0] index;
    logic               by_pos;
    logic [CODE_W-1:0]  base;
    logic [CODE_W-1:0]  single;
  } tbl_wr_t;

  // Lookup key broadcast to every cell while a scan runs.
  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [CODE_W-1:0] pos;
    logic [IDX_W-1:0]  pend_idx;
    logic [CNT_W-1:0]  n_used;
  } query_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] pend_code;
  } scan_tok_t;

  // Build one result item.
  function automatic result_t mk_res(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                     logic [ENTRY_W-1:0] entry, logic last);
    result_t r;
    r.kind      = kind;
    r.out_code  = code;
    r.out_entry = entry;
    r.last      = last;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dtko_cell.sv
// -----------------------------------------------------------------------------
// Override table cell
// Holds one table entry and checks the passing scan token against it.
// -----------------------------------------------------------------------------
`default_nettype none

module dtko_cell
  import dtko_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic [IDX_W-1:0] my_idx_i,
  input  wire tbl_wr_t   wr_i,
  input  wire query_t    query_i,
  input  wire scan_tok_t tok_i,
  output scan_tok_t      tok_o
);

  logic              by_pos_q;
  logic [CODE_W-1:0] base_q;
  logic [CODE_W-1:0] single_q;
  scan_tok_t         tok_q, tok_d;
  logic              wr_hit;
  logic              in_use;
  logic [CODE_W-1:0] key;
  logic              hit;

  // Entry storage, written when the broadcast index names this cell.
  assign wr_hit = wr_i.we &&
                  ({{IDX_W{1'b0}}, wr_i.index} == {{ENTRY_W{1'b0}}, my_idx_i});

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      by_pos_q <= wr_i.by_pos;
      base_q   <= wr_i.base;
      single_q <= wr_i.single;
    end
  end

  // Match check: the first entry in use that matches claims the token.
  assign in_use = {{CNT_W{1'b0}}, my_idx_i} < {{IDX_W{1'b0}}, query_i.n_used};
  assign key    = by_pos_q ? query_i.pos : query_i.key_code;
  assign hit    = tok_i.valid && !tok_i.found && in_use && (key == base_q);

  always_comb begin
    tok_d           = tok_i;
    tok_d.found     = tok_i.found || hit;
    tok_d.idx       = hit ? my_idx_i : tok_i.idx;
    // The pending entry drops its single code into the token on the way past.
    tok_d.pend_code = (my_idx_i == query_i.pend_idx) ? single_q : tok_i.pend_code;
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> rtl/dtko_chain.sv
// -----------------------------------------------------------------------------
// Override table chain
// Row of table cells; the scan token moves one cell per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module dtko_chain
  import dtko_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tbl_wr_t   wr_i,
  input  wire query_t    query_i,
  input  wire scan_tok_t tok_i,
  output scan_tok_t      tok_o
);

  scan_tok_t tok[ENTRIES+1];

  assign tok[0] = tok_i;

  // One cell per table entry, each handing its token to the next.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dtko_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (IDX_W'(g)),
      .wr_i     (wr_i),
      .query_i  (query_i),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  assign tok_o = tok[ENTRIES];

endmodule

`default_nettype wire

>>> rtl/double_tap_key_override_unit.sv
// -----------------------------------------------------------------------------
// Double-tap key override unit
// Detects double taps of keys listed in a table of overrides.
// -----------------------------------------------------------------------------
//
//   Channel   Signals                              Transfer
//   -------   ----------------------------------   ---------------------------
//   input     start_i, busy_o, item_i              start_i high, busy_o low
//   result    res_valid_o, res_o                   res_valid_o high, no stall
//   config    cfg_we_i, cfg_idx_i, cfg_data_i      cfg_we_i high
//
// A table write reaches the cells at the accepting edge. A key event or tick
// sends a token through the ENTRIES cells, one cell per cycle; the first
// result passes launch_q, every cell's token register and the result register,
// and a second follows in the next cycle. busy_o drops as the last one goes out.
// Reset clears the pending tap and loads the register defaults; table entries
// hold nothing until written. The receiver cannot stall results.
// -----------------------------------------------------------------------------
`default_nettype none

module double_tap_key_override_unit
  import dtko_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire item_t                item_i,
  output logic                      res_valid_o,
  output result_t                   res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_EMIT2 = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              launch_q, launch_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;
  result_t           hold_q, hold_d;
  logic              pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic [CODE_W-1:0] pend_time_q, pend_time_d;
  logic [TERM_W-1:0]  tap_term_q;
  logic [COUNT_W-1:0] entry_count_q;

  // Item fields captured at accept.
  logic [CMD_W-1:0]  cmd_q;
  logic              press_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] pos_q;
  logic [BYTE_W-1:0] mods_q;
  logic [CODE_W-1:0] now_q;

  logic              accept;
  tbl_wr_t           wr;
  query_t            query;
  scan_tok_t         tok_in, tok_out;
  logic [CODE_W-1:0] elapsed;
  logic              in_term;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_term_q    <= TAP_TERM_RST;
      entry_count_q <= ENTRY_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_TERM:    tap_term_q    <= cfg_data_i[TERM_W-1:0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item for the scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= item_i.command;
      press_q <= item_i.is_press;
      code_q  <= item_i.key_code;
      pos_q   <= {item_i.matrix_row, item_i.matrix_col};
      mods_q  <= item_i.mods_held;
      now_q   <= item_i.now_ms;
    end
  end

  // Table writes go straight to the cells.
  always_comb begin
    wr.we     = accept && (item_i.command == CMD_WRITE);
    wr.index  = item_i.entry_index;
    wr.by_pos = item_i.entry_by_position;
    wr.base   = item_i.entry_base_id;
    wr.single = item_i.entry_single_code;
  end

  // Lookup key; entry count is clamped to the table size.
  always_comb begin
    query.key_code = code_q;
    query.pos      = pos_q;
    query.pend_idx = pend_idx_q;
    if ({{(CNT_W + 1){1'b0}}, entry_count_q} > (CNT_W + COUNT_W + 1)'(ENTRIES)) begin
      query.n_used = CNT_W'(ENTRIES);
    end else begin
      query.n_used = CNT_W'(entry_count_q);
    end
  end

  assign tok_in = '{valid: launch_q, found: 1'b0, idx: '0, pend_code: '0};

  dtko_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .query_i (query),
    .tok_i   (tok_in),
    .tok_o   (tok_out)
  );

  assign elapsed = now_q - pend_time_q;
  assign in_term = (elapsed <= tap_term_q);

  // Sequencer and result decision once the token leaves the last cell.
  always_comb begin
    state_d      = state_q;
    launch_d     = 1'b0;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    hold_d       = hold_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_time_d  = pend_time_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.command == CMD_KEY || item_i.command == CMD_TICK)) begin
          launch_d = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_out.valid) begin
          state_d = ST_IDLE;
          if (cmd_q == CMD_TICK) begin
            // Timeout flush of the pending tap.
            if (pend_valid_q && !in_term) begin
              res_valid_d  = 1'b1;
              res_d        = mk_res(KIND_SINGLE, tok_out.pend_code, '0, 1'b1);
              pend_valid_d = 1'b0;
            end
          end else if (mods_q != '0) begin
            // Modifiers held: pass through, pending tap untouched.
            res_valid_d = 1'b1;
            res_d       = mk_res(KIND_PASS, '0, '0, 1'b1);
          end else if (!tok_out.found) begin
            // Unrelated event flushes the pending tap, then passes.
            res_valid_d = 1'b1;
            if (pend_valid_q) begin
              res_d        = mk_res(KIND_SINGLE, tok_out.pend_code, '0, 1'b0);
              hold_d       = mk_res(KIND_PASS, '0, '0, 1'b1);
              pend_valid_d = 1'b0;
              state_d      = ST_EMIT2;
            end else begin
              res_d = mk_res(KIND_PASS, '0, '0, 1'b1);
            end
          end else if (!press_q) begin
            // Release of a matched key is swallowed.
            res_valid_d = 1'b1;
            res_d       = mk_res(KIND_CONSUME, '0, '0, 1'b1);
          end else if (pend_valid_q && pend_idx_q == tok_out.idx && in_term) begin
            // Second press in time: double action.
            res_valid_d  = 1'b1;
            res_d        = mk_res(KIND_DOUBLE, '0, ENTRY_W'(tok_out.idx), 1'b1);
            pend_valid_d = 1'b0;
          end else begin
            // New pending press, flushing any older one first.
            res_valid_d  = 1'b1;
            pend_valid_d = 1'b1;
            pend_idx_d   = tok_out.idx;
            pend_time_d  = now_q;
            if (pend_valid_q) begin
              res_d   = mk_res(KIND_SINGLE, tok_out.pend_code, '0, 1'b0);
              hold_d  = mk_res(KIND_CONSUME, '0, '0, 1'b1);
              state_d = ST_EMIT2;
            end else begin
              res_d = mk_res(KIND_CONSUME, '0, '0, 1'b1);
            end
          end
        end
      end
      ST_EMIT2: begin
        res_valid_d = 1'b1;
        res_d       = hold_q;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      launch_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      pend_time_q  <= '0;
    end else begin
      state_q      <= state_d;
      launch_q     <= launch_d;
      res_valid_q  <= res_valid_d;
      pend_valid_q <= pend_valid_d;
      pend_idx_q   <= pend_idx_d;
      pend_time_q  <= pend_time_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    hold_q <= hold_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> tb/dtko_tap_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Double-tap override checker
// Watches the item, result and register channels of the override unit. It
// keeps its own copy of the override table, the pending tap and the register
// settings, works out the results each accepted item should cause, and compares
// every strobed result against the oldest outstanding one.
// -----------------------------------------------------------------------------

module dtko_tap_checker
  import dtko_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  item_t                item_i,
  input  logic                 res_valid_i,
  input  result_t              res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   outstanding_o,
  output int                   items_taken_o,
  output int                   results_seen_o,
  output int                   doubles_seen_o,
  output int                   flushes_seen_o
);

  localparam int MAX_REPORTS = 10;

  // Register settings as the unit should hold them.
  logic [TERM_W-1:0]  term;
  logic [COUNT_W-1:0] count;

  // Pending tap and the override table.
  logic               pend_valid;
  logic [IDX_W-1:0]   pend_entry;
  logic [CODE_W-1:0]  pend_time;
  logic               tbl_by_pos [ENTRIES];
  logic [CODE_W-1:0]  tbl_base   [ENTRIES];
  logic [CODE_W-1:0]  tbl_single [ENTRIES];

  // Results of the item being resolved, and everything still awaited.
  result_t out_buf [2];
  int      out_n;
  result_t awaited [$];
  result_t want;

  // Append one result for the current item.
  function automatic void add_result(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                     logic [ENTRY_W-1:0] entry);
    result_t r;
    r.kind      = kind;
    r.out_code  = code;
    r.out_entry = entry;
    r.last      = 1'b0;
    out_buf[out_n] = r;
    out_n++;
  endfunction

  // Tap the single code of the pending entry, read from the table as it is now.
  function automatic void flush_pending();
    if (pend_valid) begin
      add_result(KIND_SINGLE, tbl_single[pend_entry], '0);
      pend_valid = 1'b0;
    end
  endfunction

  // Work out the results of one accepted item and queue them.
  function automatic void resolve_item(item_t it);
    int                limit;
    logic              found;
    logic [IDX_W-1:0]  hit;
    logic [CODE_W-1:0] place;
    logic [CODE_W-1:0] gap;
    result_t           r;
    out_n = 0;
    found = 1'b0;
    hit   = '0;
    place = {it.matrix_row, it.matrix_col};
    gap   = it.now_ms - pend_time;
    case (it.command)
      CMD_WRITE: begin
        tbl_by_pos[it.entry_index] = it.entry_by_position;
        tbl_base[it.entry_index]   = it.entry_base_id;
        tbl_single[it.entry_index] = it.entry_single_code;
      end
      CMD_TICK: begin
        if (pend_valid && gap > term) flush_pending();
      end
      CMD_KEY: begin
        if (it.mods_held != '0) begin
          add_result(KIND_PASS, '0, '0);
        end else begin
          // The lowest matching entry in use wins.
          limit = (count > ENTRIES) ? ENTRIES : count;
          for (int i = 0; i < limit; i++) begin
            if (!found && (tbl_by_pos[i] ? place : it.key_code) == tbl_base[i]) begin
              found = 1'b1;
              hit   = IDX_W'(i);
            end
          end
          if (!found) begin
            flush_pending();
            add_result(KIND_PASS, '0, '0);
          end else if (!it.is_press) begin
            add_result(KIND_CONSUME, '0, '0);
          end else if (pend_valid && pend_entry == hit && gap <= term) begin
            pend_valid = 1'b0;
            add_result(KIND_DOUBLE, '0, hit);
          end else begin
            flush_pending();
            pend_valid = 1'b1;
            pend_entry = hit;
            pend_time  = it.now_ms;
            add_result(KIND_CONSUME, '0, '0);
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < out_n; k++) begin
      r = out_buf[k];
      r.last = (k == out_n - 1);
      awaited.push_back(r);
    end
  endfunction

  // Results are checked before the item taken at the same edge is resolved.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term           = TAP_TERM_RST;
      count          = ENTRY_COUNT_RST;
      pend_valid     = 1'b0;
      pend_entry     = '0;
      pend_time      = '0;
      awaited.delete();
      fail_count_o   = 0;
      outstanding_o  = 0;
      items_taken_o  = 0;
      results_seen_o = 0;
      doubles_seen_o = 0;
      flushes_seen_o = 0;
    end else begin
      if (res_valid_i) begin
        results_seen_o++;
        if (awaited.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS) begin
            $display("ERROR: unexpected result kind %0d code %h entry %0d last %b",
                     res_i.kind, res_i.out_code, res_i.out_entry, res_i.last);
          end
        end else begin
          want = awaited.pop_front();
          if (res_i.kind !== want.kind || res_i.out_code !== want.out_code ||
              res_i.out_entry !== want.out_entry || res_i.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("ERROR: result %0d expected kind %0d code %h entry %0d last %b",
                       results_seen_o, want.kind, want.out_code, want.out_entry,
                       want.last);
              $display("       got kind %0d code %h entry %0d last %b",
                       res_i.kind, res_i.out_code, res_i.out_entry, res_i.last);
            end
          end
          if (want.kind == KIND_DOUBLE) doubles_seen_o++;
          if (want.kind == KIND_SINGLE) flushes_seen_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAP_TERM:    term  = cfg_data_i[TERM_W-1:0];
          CFG_ENTRY_COUNT: count = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        items_taken_o++;
        resolve_item(item_i);
      end
      outstanding_o = awaited.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Double-tap override unit testbench
// Loads the override table, runs a directed set of tap sequences and then
// random key, tick and table traffic under several tap terms and entry counts.
// A checker beside the unit predicts and compares every result.
// -----------------------------------------------------------------------------

module tb;
  import dtko_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = ENTRIES + 6;
  localparam int PHASES       = 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  item_t                item_i;
  logic                 res_valid_o;
  result_t              res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int fail_count;
  int outstanding;
  int items_taken;
  int results_seen;
  int doubles_seen;
  int flushes_seen;
  int cycle_count = 0;

  // What the stimulus knows of the table and settings, used to aim key events.
  logic              map_by_pos [ENTRIES];
  logic [CODE_W-1:0] map_base   [ENTRIES];
  logic [CODE_W-1:0] t_now;
  logic [TERM_W-1:0] term_now;
  int                count_now;
  int                last_idx;
  logic              steady;
  int                settings_run;

  double_tap_key_override_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  dtko_tap_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .item_i         (item_i),
    .res_valid_i    (res_valid_o),
    .res_i          (res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .items_taken_o  (items_taken),
    .results_seen_o (results_seen),
    .doubles_seen_o (doubles_seen),
    .flushes_seen_o (flushes_seen)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
      $display("double_tap_key_override_unit test failed");
      $finish;
    end
  end

  // Present one item and hold it until the unit takes it.
  task automatic send(item_t it);
    @(negedge clk_i);
    item_i  <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Leave the item channel quiet for a span set by n; n of zero does nothing.
  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Often back to back, often a short gap, now and then a long one; no gaps when steady.
  task automatic pause_random();
    int r;
    r = $urandom_range(0, 99);
    if (!steady) begin
      if (r < 45) pause(0);
      else if (r < 85) pause($urandom_range(1, 20));
      else pause($urandom_range(21, 60));
    end
  endtask

  // Wait until every expected result is out and the unit has gone quiet.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outstanding != 0 || busy_o) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic put_entry(logic [ENTRY_W-1:0] idx, logic by_pos, logic [CODE_W-1:0] base,
                           logic [CODE_W-1:0] single);
    item_t it;
    it = {$urandom(), $urandom(), $urandom()};
    it.command           = CMD_WRITE;
    it.entry_index       = idx;
    it.entry_by_position = by_pos;
    it.entry_base_id     = base;
    it.entry_single_code = single;
    map_by_pos[idx] = by_pos;
    map_base[idx]   = base;
    send(it);
  endtask

  task automatic key_event(logic press, logic [CODE_W-1:0] code, logic [CODE_W-1:0] place,
                           logic [BYTE_W-1:0] mods, logic [CODE_W-1:0] stamp);
    item_t it;
    it = {$urandom(), $urandom(), $urandom()};
    it.command    = CMD_KEY;
    it.is_press   = press;
    it.key_code   = code;
    it.matrix_row = place[15:8];
    it.matrix_col = place[7:0];
    it.mods_held  = mods;
    it.now_ms     = stamp;
    send(it);
  endtask

  task automatic tick_at(logic [CODE_W-1:0] stamp);
    item_t it;
    it = {$urandom(), $urandom(), $urandom()};
    it.command = CMD_TICK;
    it.now_ms  = stamp;
    send(it);
  endtask

  // Time step between items, biased toward the tap term boundary.
  function automatic logic [CODE_W-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return term_now;
      2: return term_now + 16'd1;
      3: return CODE_W'($urandom());
      default: return CODE_W'($urandom_range(0, (term_now > 1000) ? 2000 : 2 * term_now + 2));
    endcase
  endfunction

  // One random item: mostly presses and releases of table keys, with repeats
  // of the last key to form double taps, plus ticks, noise and table rewrites.
  task automatic random_item();
    item_t it;
    int    sel;
    int    idx;
    it  = {$urandom(), $urandom(), $urandom()};
    sel = $urandom_range(0, 99);
    t_now = t_now + pick_delta();
    it.now_ms = t_now;
    if (sel < 2) begin
      it.command = CMD_UNUSED;
    end else if (sel < 5) begin
      it.command = CMD_WRITE;
      if ($urandom_range(0, 2) == 0) it.entry_base_id = map_base[$urandom_range(0, ENTRIES - 1)];
      map_by_pos[it.entry_index] = it.entry_by_position;
      map_base[it.entry_index]   = it.entry_base_id;
    end else if (sel < 17) begin
      it.command = CMD_TICK;
    end else begin
      it.command   = CMD_KEY;
      it.mods_held = '0;
      if (sel < 23) begin
        it.mods_held = BYTE_W'($urandom_range(1, 255));
      end else if (sel >= 33) begin
        if (count_now == 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, ENTRIES - 1);
        else if ($urandom_range(0, 1) == 1) idx = last_idx;
        else idx = $urandom_range(0, ((count_now > ENTRIES) ? ENTRIES : count_now) - 1);
        last_idx    = idx;
        it.is_press = ($urandom_range(0, 4) != 0);
        if (map_by_pos[idx]) {it.matrix_row, it.matrix_col} = map_base[idx];
        else it.key_code = map_base[idx];
      end
    end
    send(it);
  endtask

  // Stimulus and verdict.
  initial begin
    int phase_items;
    int count_set;
    start_i    = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    steady     = 1'b0;
    last_idx   = 0;
    t_now      = '0;
    term_now   = TAP_TERM_RST;
    count_now  = int'(ENTRY_COUNT_RST);
    settings_run = 1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Fill the whole table before any entry is put in use. Entry 0 shadows
    // entry 2, and the corners of the code and position spaces are present.
    put_entry(4'd0, 1'b0, 16'h0004, 16'hA001);
    put_entry(4'd1, 1'b1, 16'h0203, 16'hA002);
    put_entry(4'd2, 1'b0, 16'h0004, 16'hA003);
    put_entry(4'd3, 1'b1, 16'hFFFF, 16'hFFFF);
    put_entry(4'd4, 1'b0, 16'h0000, 16'h0000);
    put_entry(4'd5, 1'b0, 16'hFFFF, 16'h8000);
    for (int i = 6; i < ENTRIES; i++) begin
      put_entry(ENTRY_W'(i), i[0] == 1'b0, {8'h40 + i[7:0], 8'h50 + i[7:0]},
                CODE_W'($urandom()));
    end
    drain();
    write_reg(CFG_ENTRY_COUNT, CFG_W'(ENTRIES));
    count_now = ENTRIES;

    // Directed tap sequences with the default tap term.
    key_event(1'b1, 16'h0004, 16'h1020, 8'h00, 16'd1000);  // first tap held
    key_event(1'b1, 16'h0004, 16'h1020, 8'h00, 16'd1200);  // second tap right at the term
    key_event(1'b1, 16'h0077, 16'h0203, 8'h00, 16'd1300);  // position match held
    key_event(1'b1, 16'h0077, 16'h0203, 8'h00, 16'd1501);  // one past the term: flush and hold
    key_event(1'b0, 16'h0004, 16'h1020, 8'h00, 16'd1510);  // release of a matched key
    key_event(1'b1, 16'h0004, 16'h1020, 8'h80, 16'd1520);  // modifier passes through
    tick_at(16'd1600);                                     // still inside the term
    tick_at(16'd1702);                                     // timeout flush
    tick_at(16'd1800);                                     // nothing pending
    key_event(1'b1, 16'h0077, 16'hFFFF, 8'h00, 16'd65500);
    key_event(1'b1, 16'h0077, 16'hFFFF, 8'h00, 16'd100);   // double tap across the time wrap
    key_event(1'b1, 16'h0004, 16'h1020, 8'h00, 16'd200);
    key_event(1'b1, 16'h1234, 16'h1122, 8'h00, 16'd250);   // unmatched press flushes
    key_event(1'b0, 16'h1234, 16'h1122, 8'h00, 16'd260);   // unmatched release
    key_event(1'b1, 16'h0000, 16'h1020, 8'h00, 16'd300);
    key_event(1'b1, 16'hFFFF, 16'h1020, 8'h00, 16'd310);   // another entry flushes the first
    put_entry(4'd5, 1'b0, 16'hFFFF, 16'h5A5A);             // rewrite under a pending tap
    tick_at(16'd700);                                      // flush reads the new code
    t_now = 16'd700;
    random_item();
    key_event(1'b1, 16'h0004, 16'h1020, 8'hFF, 16'd720);
    t_now = 16'd720;
    drain();

    // Random traffic under a series of register settings.
    for (int p = 0; p < PHASES; p++) begin
      phase_items = 200;
      case (p)
        0: begin term_now = 16'd200;   count_set = 16; phase_items = 250; end
        1: begin term_now = 16'd0;     count_set = 16; end
        2: begin term_now = 16'hFFFF;  count_set = 16; end
        3: begin term_now = 16'd5;     count_set = 3;  end
        4: begin term_now = 16'd1000;  count_set = 1;  end
        5: begin term_now = 16'd300;   count_set = 0;  phase_items = 100; end
        6: begin term_now = 16'd50;    count_set = 31; phase_items = 250; end
        default: begin term_now = TERM_W'($urandom()); count_set = 17; end
      endcase
      // The upper data bits ride along to show they do not reach the count.
      write_reg(CFG_TAP_TERM, term_now);
      write_reg(CFG_ENTRY_COUNT, CFG_W'(($urandom() & 32'hFFE0) | count_set));
      count_now = count_set;
      settings_run++;
      steady = (p == 2);
      for (int n = 0; n < phase_items; n++) begin
        if (p == 3 && n == phase_items / 2) drain();
        pause_random();
        random_item();
      end
      drain();
    end

    $display("Covered %0d items and %0d results (%0d double taps, %0d single-tap flushes)",
             items_taken, results_seen, doubles_seen, flushes_seen);
    $display("across %0d register settings, including tap terms of 0 and 65535.",
             settings_run);
    if (outstanding != 0) $display("ERROR: %0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("double_tap_key_override_unit test passed");
    end else begin
      $display("double_tap_key_override_unit test failed");
    end
    $finish;
  end

endmodule
